### rtl/pid_distance_stepper_control_defines.svh
// Assertion macros used by the checker file of the stepper controller
`ifndef PID_DISTANCE_STEPPER_CONTROL_DEFINES_SVH
`define PID_DISTANCE_STEPPER_CONTROL_DEFINES_SVH

// Checked at every rising edge outside reset
`define PDSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every rising edge, reset included
`define PDSC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/pdsc_pkg.sv
// Shared types and constants of the distance-holding PID stepper controller
`timescale 1ns / 1ps

package pdsc_pkg;

    // Field and datapath widths
    localparam int ECHO_W        = 16;
    localparam int DIST_W        = 14;
    localparam int ERR_W         = 15;
    localparam int LAST_ERR_W    = 16;
    localparam int INTEGRAL_BITS = 24;
    localparam int RUN_W         = 4;
    localparam int DRV_W         = 11;
    localparam int LIM_W         = 10;
    localparam int STEP_W        = 6;
    localparam int GAIN_W        = 16;

    // Shared multiplier: unsigned gains widened to signed by one bit
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = (INTEGRAL_BITS > ECHO_W) ? INTEGRAL_BITS : ECHO_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int QUO_W   = ACC_W - 8;

    // Echo width in us to mm, Q16 scale (0.343 / 2 mm per us)
    localparam logic signed [MUL_A_W-1:0] DIST_SCALE = MUL_A_W'(11239);
    localparam int DIST_LSB = 16;

    // Integral clears after this many settled control cycles in a row
    localparam logic [RUN_W-1:0] SETTLE_CYCLES = RUN_W'(9);

    // APB
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_SETPOINT  = 3'd0,
        REG_GAIN_P    = 3'd1,
        REG_GAIN_I    = 3'd2,
        REG_GAIN_D    = 3'd3,
        REG_INT_WIN   = 3'd4,
        REG_SETTLE    = 3'd5,
        REG_DRV_LIMIT = 3'd6,
        REG_MAX_STEPS = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [11:0]       setpoint_mm;
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [11:0]       integral_window;
        logic [7:0]        settle_band;
        logic [LIM_W-1:0]  drive_limit;
        logic [STEP_W-1:0] max_steps;
    } cfg_t;

    // Operand pair selected for the shared multiplier
    typedef enum logic [1:0] {
        MSEL_DIST = 2'd0,
        MSEL_P    = 2'd1,
        MSEL_I    = 2'd2,
        MSEL_D    = 2'd3
    } mul_sel_t;

    // Sequencer strobes to the datapath
    typedef struct packed {
        logic     busy;
        logic     accept;
        logic     ld_err;
        logic     acc_load;
        logic     acc_add;
        logic     ld_drive;
        logic     ld_out;
        mul_sel_t mul_sel;
    } ctrl_t;

endpackage

### rtl/pdsc_cfg.sv
// APB register file holding the controller settings
`timescale 1ns / 1ps

module pdsc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pdsc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pdsc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pdsc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output pdsc_pkg::cfg_t                   cfg
);
    import pdsc_pkg::*;

    cfg_t     cfg_reg;
    cfg_idx_t idx;
    logic     wr_en;

    assign idx    = cfg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint_mm     <= 12'd170;
            cfg_reg.gain_p          <= GAIN_W'(333);
            cfg_reg.gain_i          <= GAIN_W'(26);
            cfg_reg.gain_d          <= GAIN_W'(1792);
            cfg_reg.integral_window <= 12'd70;
            cfg_reg.settle_band     <= 8'd5;
            cfg_reg.drive_limit     <= LIM_W'(288);
            cfg_reg.max_steps       <= STEP_W'(40);
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SETPOINT:  cfg_reg.setpoint_mm     <= pwdata[11:0];
                REG_GAIN_P:    cfg_reg.gain_p          <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:    cfg_reg.gain_i          <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:    cfg_reg.gain_d          <= pwdata[GAIN_W-1:0];
                REG_INT_WIN:   cfg_reg.integral_window <= pwdata[11:0];
                REG_SETTLE:    cfg_reg.settle_band     <= pwdata[7:0];
                REG_DRV_LIMIT: cfg_reg.drive_limit     <= pwdata[LIM_W-1:0];
                REG_MAX_STEPS: cfg_reg.max_steps       <= pwdata[STEP_W-1:0];
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_SETPOINT:  prdata = APB_DATA_W'(cfg_reg.setpoint_mm);
            REG_GAIN_P:    prdata = APB_DATA_W'(cfg_reg.gain_p);
            REG_GAIN_I:    prdata = APB_DATA_W'(cfg_reg.gain_i);
            REG_GAIN_D:    prdata = APB_DATA_W'(cfg_reg.gain_d);
            REG_INT_WIN:   prdata = APB_DATA_W'(cfg_reg.integral_window);
            REG_SETTLE:    prdata = APB_DATA_W'(cfg_reg.settle_band);
            REG_DRV_LIMIT: prdata = APB_DATA_W'(cfg_reg.drive_limit);
            REG_MAX_STEPS: prdata = APB_DATA_W'(cfg_reg.max_steps);
        endcase
    end

endmodule

### rtl/pdsc_mul.sv
// Shared signed multiplier with operand select and registered product
`timescale 1ns / 1ps

module pdsc_mul (
    input  logic                                    clk,
    input  pdsc_pkg::mul_sel_t                      sel,
    input  pdsc_pkg::cfg_t                          cfg,
    input  logic [pdsc_pkg::ECHO_W-1:0]             echo,
    input  logic signed [pdsc_pkg::ERR_W-1:0]       err,
    input  logic signed [pdsc_pkg::INTEGRAL_BITS-1:0] integ,
    input  logic signed [pdsc_pkg::LAST_ERR_W-1:0]  diff,
    output logic signed [pdsc_pkg::PROD_W-1:0]      prod
);
    import pdsc_pkg::*;

    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_reg;

    // operand select: scale factor or a gain against one state value
    always_comb
    begin
        unique case (sel)
            MSEL_DIST:
            begin
                op_a = DIST_SCALE;
                op_b = {{(MUL_B_W-ECHO_W){1'b0}}, echo};
            end
            MSEL_P:
            begin
                op_a = {1'b0, cfg.gain_p};
                op_b = {{(MUL_B_W-ERR_W){err[ERR_W-1]}}, err};
            end
            MSEL_I:
            begin
                op_a = {1'b0, cfg.gain_i};
                op_b = MUL_B_W'(integ);
            end
            MSEL_D:
            begin
                op_a = {1'b0, cfg.gain_d};
                op_b = {{(MUL_B_W-LAST_ERR_W){diff[LAST_ERR_W-1]}}, diff};
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

### rtl/pdsc_seq.sv
// Sequencer stepping one control cycle through the shared multiplier
`timescale 1ns / 1ps

module pdsc_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            out_hold,
    output pdsc_pkg::ctrl_t ctrl
);
    import pdsc_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_DIST = 9'b000000010,
        ST_ERR  = 9'b000000100,
        ST_MP   = 9'b000001000,
        ST_MI   = 9'b000010000,
        ST_MD   = 9'b000100000,
        ST_ACC  = 9'b001000000,
        ST_DRV  = 9'b010000000,
        ST_STEP = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and strobes
    always_comb
    begin
        state_next    = state_reg;
        ctrl          = '0;
        ctrl.busy     = 1'b1;
        ctrl.mul_sel  = MSEL_DIST;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.busy   = 1'b0;
                ctrl.accept = in_valid;
                if (in_valid)
                    state_next = ST_DIST;
            end
            ST_DIST:
            begin
                ctrl.mul_sel = MSEL_DIST;
                state_next   = ST_ERR;
            end
            ST_ERR:
            begin
                ctrl.ld_err = 1'b1;
                state_next  = ST_MP;
            end
            ST_MP:
            begin
                ctrl.mul_sel = MSEL_P;
                state_next   = ST_MI;
            end
            ST_MI:
            begin
                ctrl.mul_sel  = MSEL_I;
                ctrl.acc_load = 1'b1;
                state_next    = ST_MD;
            end
            ST_MD:
            begin
                ctrl.mul_sel = MSEL_D;
                ctrl.acc_add = 1'b1;
                state_next   = ST_ACC;
            end
            ST_ACC:
            begin
                ctrl.acc_add = 1'b1;
                state_next   = ST_DRV;
            end
            ST_DRV:
            begin
                ctrl.ld_drive = 1'b1;
                state_next    = ST_STEP;
            end
            ST_STEP:
            begin
                // wait while the previous result is still unclaimed
                if (!out_hold)
                begin
                    ctrl.ld_out = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
        endcase
    end

endmodule

### rtl/pid_distance_stepper_control.sv
// Top level of the distance-holding PID controller with stepper output
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ------------------------------------------
//  in        sink       in_valid / in_stall   echo_us
//  out       source     out_valid / out_stall error_mm, drive_target, step_count,
//                                             step_dir, angle_now
//  config    APB slave  psel/penable/pready   paddr, pwdata, prdata
//
// A transaction runs from acceptance through DIST, ERR, MP, MI, MD, ACC, DRV
// and STEP to the result register: the 17x24 multiplier is used four times in
// turn (distance, P, I, D terms); no new transaction is taken before then.
// in_stall is high meanwhile; the block takes the next item while the result
// waits, but holds its last step while an older result is unclaimed.
// Reset clears the settings to defaults and the integral, last error,
// settle count and motor angle to zero.
`timescale 1ns / 1ps

module pid_distance_stepper_control (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [pdsc_pkg::ECHO_W-1:0]            echo_us,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pdsc_pkg::ERR_W-1:0]      error_mm,
    output logic signed [pdsc_pkg::DRV_W-1:0]      drive_target,
    output logic [pdsc_pkg::STEP_W-1:0]            step_count,
    output logic                                   step_dir,
    output logic signed [pdsc_pkg::DRV_W-1:0]      angle_now,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [pdsc_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [pdsc_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [pdsc_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);
    import pdsc_pkg::*;

    localparam logic signed [INTEGRAL_BITS-1:0] INT_MAX = {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
    localparam logic signed [INTEGRAL_BITS-1:0] INT_MIN = {1'b1, {(INTEGRAL_BITS-1){1'b0}}};

    cfg_t  cfg;
    ctrl_t ctrl;
    logic  out_hold;

    // controller state
    logic [ECHO_W-1:0]                echo_reg;
    logic signed [ERR_W-1:0]          err_reg;
    logic signed [LAST_ERR_W-1:0]     diff_reg;
    logic signed [LAST_ERR_W-1:0]     last_err_reg;
    logic signed [INTEGRAL_BITS-1:0]  integ_reg;
    logic signed [INTEGRAL_BITS-1:0]  integ_next;
    logic [RUN_W-1:0]                 run_reg;
    logic [RUN_W-1:0]                 run_next;
    logic signed [ACC_W-1:0]          acc_reg;
    logic signed [DRV_W-1:0]          drive_reg;
    logic signed [DRV_W-1:0]          drive_next;
    logic signed [DRV_W-1:0]          angle_reg;
    logic signed [DRV_W-1:0]          angle_next;
    logic                             out_valid_reg;

    // output register
    logic signed [ERR_W-1:0]          error_mm_reg;
    logic signed [DRV_W-1:0]          drive_target_reg;
    logic [STEP_W-1:0]                step_count_reg;
    logic                             step_dir_reg;
    logic signed [DRV_W-1:0]          angle_now_reg;

    logic signed [PROD_W-1:0]         prod;

    pdsc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdsc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_hold (out_hold),
        .ctrl     (ctrl)
    );

    pdsc_mul u_mul (
        .clk   (clk),
        .sel   (ctrl.mul_sel),
        .cfg   (cfg),
        .echo  (echo_reg),
        .err   (err_reg),
        .integ (integ_reg),
        .diff  (diff_reg),
        .prod  (prod)
    );

    assign in_stall = ctrl.busy;
    assign out_hold = out_valid_reg && out_stall;

    // error, window and settle logic
    logic [DIST_W-1:0]              dist_mm;
    logic signed [ERR_W-1:0]        err_c;
    logic [ERR_W-1:0]               mag;
    logic                           in_window;
    logic                           in_band;
    logic signed [INTEGRAL_BITS:0]  isum;
    logic signed [INTEGRAL_BITS-1:0] integ_acc;
    logic signed [LAST_ERR_W-1:0]   err_ext;
    logic signed [LAST_ERR_W-1:0]   diff_next;

    assign dist_mm   = prod[DIST_LSB+DIST_W-1:DIST_LSB];
    assign err_c     = signed'({{(ERR_W-12){1'b0}}, cfg.setpoint_mm})
                     - signed'({{(ERR_W-DIST_W){1'b0}}, dist_mm});
    assign mag       = err_c[ERR_W-1] ? ERR_W'(-err_c) : ERR_W'(err_c);
    assign in_window = mag <= {{(ERR_W-12){1'b0}}, cfg.integral_window};
    assign in_band   = mag <= {{(ERR_W-8){1'b0}}, cfg.settle_band};
    assign isum      = {integ_reg[INTEGRAL_BITS-1], integ_reg}
                     + {{(INTEGRAL_BITS+1-ERR_W){err_c[ERR_W-1]}}, err_c};
    assign err_ext   = {{(LAST_ERR_W-ERR_W){err_c[ERR_W-1]}}, err_c};
    assign diff_next = err_ext - last_err_reg;

    always_comb
    begin
        // saturating accumulate inside the window
        if (!in_window)
            integ_acc = integ_reg;
        else if (isum[INTEGRAL_BITS] != isum[INTEGRAL_BITS-1])
            integ_acc = isum[INTEGRAL_BITS] ? INT_MIN : INT_MAX;
        else
            integ_acc = isum[INTEGRAL_BITS-1:0];

        if (!in_band)
            run_next = '0;
        else if (run_reg < SETTLE_CYCLES)
            run_next = run_reg + 1'b1;
        else
            run_next = run_reg;

        integ_next = (run_next >= SETTLE_CYCLES) ? '0 : integ_acc;
    end

    // divide by 256 toward zero, then clamp
    logic signed [ACC_W-1:0] acc_adj;
    logic signed [QUO_W-1:0] quo;
    logic signed [QUO_W-1:0] lim_pos;
    logic signed [QUO_W-1:0] lim_neg;

    assign acc_adj = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
    assign quo     = acc_adj[ACC_W-1:8];
    assign lim_pos = {{(QUO_W-LIM_W){1'b0}}, cfg.drive_limit};
    assign lim_neg = -lim_pos;

    always_comb
    begin
        priority if (quo > lim_pos)
            drive_next = lim_pos[DRV_W-1:0];
        else if (quo < lim_neg)
            drive_next = lim_neg[DRV_W-1:0];
        else
            drive_next = quo[DRV_W-1:0];
    end

    // step limiting toward the drive target
    logic signed [DRV_W:0] delta;
    logic                  dir;
    logic [DRV_W:0]        dist_steps;
    logic [STEP_W-1:0]     steps;

    assign delta      = {drive_reg[DRV_W-1], drive_reg} - {angle_reg[DRV_W-1], angle_reg};
    assign dir        = delta[DRV_W];
    assign dist_steps = dir ? (DRV_W+1)'(-delta) : (DRV_W+1)'(delta);
    assign steps      = (dist_steps > {{(DRV_W+1-STEP_W){1'b0}}, cfg.max_steps})
                      ? cfg.max_steps : dist_steps[STEP_W-1:0];
    assign angle_next = dir ? angle_reg - {{(DRV_W-STEP_W){1'b0}}, steps}
                            : angle_reg + {{(DRV_W-STEP_W){1'b0}}, steps};

    // state carried between transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg     <= '0;
            last_err_reg  <= '0;
            run_reg       <= '0;
            angle_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.ld_err)
            begin
                integ_reg    <= integ_next;
                last_err_reg <= err_ext;
                run_reg      <= run_next;
            end
            if (ctrl.ld_out)
                angle_reg <= angle_next;
            if (ctrl.ld_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
            echo_reg <= echo_us;
        if (ctrl.ld_err)
        begin
            err_reg  <= err_c;
            diff_reg <= diff_next;
        end
        if (ctrl.acc_load)
            acc_reg <= {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
        else if (ctrl.acc_add)
            acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
        if (ctrl.ld_drive)
            drive_reg <= drive_next;
        if (ctrl.ld_out)
        begin
            error_mm_reg     <= err_reg;
            drive_target_reg <= drive_reg;
            step_count_reg   <= steps;
            step_dir_reg     <= dir;
            angle_now_reg    <= angle_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign error_mm     = error_mm_reg;
    assign drive_target = drive_target_reg;
    assign step_count   = step_count_reg;
    assign step_dir     = step_dir_reg;
    assign angle_now    = angle_now_reg;

endmodule

### rtl/pdsc_checker.sv
// Port-level checks on the stepper controller, bound to the top level
`timescale 1ns / 1ps
`include "pid_distance_stepper_control_defines.svh"

module pdsc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [pdsc_pkg::ERR_W-1:0]    error_mm,
    input logic signed [pdsc_pkg::DRV_W-1:0]    drive_target,
    input logic [pdsc_pkg::STEP_W-1:0]          step_count,
    input logic                                 step_dir,
    input logic signed [pdsc_pkg::DRV_W-1:0]    angle_now
);

    // an accepted transaction keeps the input side busy
    `PDSC_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "no busy after accept")

    // a result only appears at the end of a busy stretch
    `PDSC_ASSERT(a_result_after_busy, $rose(out_valid) |-> $past(in_stall), "result without work")

    // drive and angle stay inside the symmetric range
    `PDSC_ASSERT(a_range, out_valid |-> drive_target != 11'h400 && angle_now != 11'h400, "range")

    // a stalled result holds
    `PDSC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(error_mm) && $stable(drive_target) && $stable(step_count) && $stable(step_dir) && $stable(angle_now), "stalled result changed")

    // a clock edge in reset leaves both channels quiet
    `PDSC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && !in_stall, "activity in reset")

endmodule

bind pid_distance_stepper_control pdsc_checker u_pdsc_checker (.*);
